// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Simulation builds get the checks;
// synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mbi_pkg.sv =====
package mbi_pkg;

	// Field widths fixed by the interface.
	localparam int C_W     = 32;
	localparam int ESC_W   = 12;
	localparam int LIMIT_W = 12;
	localparam int WORD_W  = 64;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd800;

	// Working word: signed 64-bit fixed point.
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [WORD_W+7:0] wide_t;

	// Saturation bounds are symmetric.
	localparam word_t SAT_MAX = {1'b0, {63{1'b1}}};
	localparam word_t SAT_MIN = {1'b1, {62{1'b0}}, 1'b1};

	// Small constant multipliers of the cardioid, bulb and iteration formulas.
	localparam logic [8:0] K_CARD_SQ = 9'd256;
	localparam logic [8:0] K_CARD_C2 = 9'd96;
	localparam logic [8:0] K_CARD_CX = 9'd32;
	localparam logic [8:0] K_BULB    = 9'd16;
	localparam logic [8:0] K_DOUBLE  = 9'd2;

	// Input and result beats.
	typedef struct packed {
		logic signed [C_W-1:0] c_real;
		logic signed [C_W-1:0] c_imag;
	} item_t;

	typedef struct packed {
		logic [ESC_W-1:0] escape_count;
		logic             escaped;
		logic             rejected_early;
	} result_t;

	// Request and response between the sequencer and the shared multiplier.
	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
	} mul_req_t;

	typedef struct packed {
		logic  done;
		word_t p;
	} mul_rsp_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CXX,
		S_CYY,
		S_C2,
		S_DD,
		S_E1,
		S_E2,
		S_E3,
		S_E4,
		S_STEP1,
		S_STEP2,
		S_SX,
		S_SY,
		S_CHK,
		S_XY
	} state_t;

	function automatic wide_t sext72(word_t a);
		return {{8{a[WORD_W-1]}}, a};
	endfunction

	function automatic word_t sat_clamp(wide_t v);
		if (v > sext72(SAT_MAX)) begin
			return SAT_MAX;
		end else if (v < sext72(SAT_MIN)) begin
			return SAT_MIN;
		end
		return v[WORD_W-1:0];
	endfunction

	function automatic word_t sat_add(word_t a, word_t b);
		return sat_clamp(sext72(a) + sext72(b));
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		return sat_clamp(sext72(a) - sext72(b));
	endfunction

	// Multiply by a small constant; callers pass constants only.
	function automatic word_t sat_mulk(word_t a, logic [8:0] k);
		return sat_clamp(sext72(a) * $signed({63'd0, k}));
	endfunction

	function automatic logic [WORD_W-1:0] magnitude(word_t a);
		return a[WORD_W-1] ? (~a + 64'd1) : a;
	endfunction

endpackage

// ===== sv/mbi_mulq.sv =====
module mbi_mulq #(
	parameter int FRAC_BITS = 28
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mbi_pkg::mul_req_t req,
	output mbi_pkg::mul_rsp_t rsp
);
	import mbi_pkg::*;

	localparam int ACC_W = 2 * WORD_W;
	localparam int HALF  = WORD_W / 2;
	localparam logic [2:0] LAST_STEP = 3'd5;

	logic              run_q;
	logic [2:0]        step_q;
	logic              done_q;
	logic [WORD_W-1:0] ua_q;
	logic [WORD_W-1:0] ub_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	word_t             p_q;
	logic [WORD_W-1:0] pp_s1;
	logic [1:0]        pp_off_s1;
	logic              pp_vld_s1;

	logic [HALF-1:0]   mul_a;
	logic [HALF-1:0]   mul_b;
	logic [1:0]        off;
	logic [ACC_W-1:0]  pp_wide;
	logic              ovf;
	logic [WORD_W-1:0] m;
	word_t             mag;
	word_t             fin;

	// Partial product order: low*low, low*high, high*low, high*high.
	assign mul_a = step_q[1] ? ua_q[WORD_W-1:HALF] : ua_q[HALF-1:0];
	assign mul_b = step_q[0] ? ub_q[WORD_W-1:HALF] : ub_q[HALF-1:0];
	assign off   = {1'b0, step_q[1]} + {1'b0, step_q[0]};

	// Place the registered partial product at its weight.
	always_comb begin
		case (pp_off_s1)
			2'd0:    pp_wide = {{HALF{1'b0}}, {HALF{1'b0}}, pp_s1};
			2'd1:    pp_wide = {{HALF{1'b0}}, pp_s1, {HALF{1'b0}}};
			2'd2:    pp_wide = {pp_s1, {HALF{1'b0}}, {HALF{1'b0}}};
			default: pp_wide = '0;
		endcase
	end

	// Drop the fraction bits, saturate the magnitude and restore the sign.
	assign ovf = |acc_q[ACC_W-1:WORD_W+FRAC_BITS];
	assign m   = acc_q[FRAC_BITS +: WORD_W];
	assign mag = (ovf || m[WORD_W-1]) ? SAT_MAX : word_t'(m);
	assign fin = neg_q ? -mag : mag;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			step_q    <= '0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= !req.start && run_q && (step_q == LAST_STEP);
			if (req.start) begin
				run_q     <= 1'b1;
				step_q    <= '0;
				pp_vld_s1 <= 1'b0;
			end else if (run_q) begin
				step_q    <= step_q + 3'd1;
				pp_vld_s1 <= !step_q[2];
				if (step_q == LAST_STEP) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Operands, partial products and the accumulator.
	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q  <= magnitude(req.a);
			ub_q  <= magnitude(req.b);
			neg_q <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
			acc_q <= '0;
		end else if (run_q) begin
			pp_s1     <= 64'(mul_a) * 64'(mul_b);
			pp_off_s1 <= off;
			if (pp_vld_s1) begin
				acc_q <= acc_q + pp_wide;
			end
			if (step_q == LAST_STEP) begin
				p_q <= fin;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

endmodule

// ===== sv/mbi_core.sv =====
module mbi_core #(
	parameter int FRAC_BITS  = 28,
	parameter int COUNT_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  mbi_pkg::item_t                point,
	input  logic [mbi_pkg::LIMIT_W-1:0]   limit,
	output logic                          busy,
	output logic                          done,
	output mbi_pkg::result_t              result,
	output mbi_pkg::mul_req_t             mul_req,
	input  mbi_pkg::mul_rsp_t             mul_rsp
);
	import mbi_pkg::*;

	localparam int CNT_W = (COUNT_BITS < ESC_W) ? COUNT_BITS : ESC_W;
	localparam logic [LIMIT_W-1:0] CAP = LIMIT_W'((1 << CNT_W) - 1);
	localparam word_t ONE   = 64'sd1 <<< FRAC_BITS;
	localparam word_t THREE = 64'sd3 <<< FRAC_BITS;
	localparam word_t FOUR  = 64'sd4 <<< FRAC_BITS;

	state_t state_q, state_d;

	logic                  pend_q;
	logic                  done_q;
	result_t               res_q;
	logic signed [C_W-1:0] cx_q;
	logic signed [C_W-1:0] cy_q;
	logic [CNT_W-1:0]      lim_q;
	logic [CNT_W-1:0]      n_q;
	word_t                 sqx_q;
	word_t                 sqy_q;
	word_t                 m_q;
	word_t                 c2_q;
	word_t                 dd_q;
	word_t                 g_q;
	word_t                 t_q;
	word_t                 h_q;
	word_t                 zx_q;
	word_t                 zy_q;

	word_t            cx_w;
	word_t            cy_w;
	word_t            d_w;
	logic [CNT_W-1:0] lim_eff;
	logic             c2_big;
	logic             rej;
	logic             esc;
	logic             begin_iter;
	logic             fin;
	result_t          fin_res;

	assign cx_w = {{(WORD_W-C_W){cx_q[C_W-1]}}, cx_q};
	assign cy_w = {{(WORD_W-C_W){cy_q[C_W-1]}}, cy_q};
	assign d_w  = cx_w + ONE;

	// Limit clamped to what the counter can hold.
	assign lim_eff = (limit > CAP) ? '1 : limit[CNT_W-1:0];

	// Decisions taken from stored values.
	assign c2_big = c2_q >= FOUR;
	assign rej    = (h_q < THREE) || (sat_mulk(g_q, K_BULB) < ONE);
	assign esc    = sat_add(sqx_q, sqy_q) >= FOUR;

	assign begin_iter = (state_q == S_C2 && c2_big) || (state_q == S_E4 && !rej);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, multiplier requests and the finishing beat.
	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		fin           = 1'b0;
		fin_res       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_CXX;
				end
			end
			S_CXX: begin
				mul_req.start = !pend_q;
				mul_req.a     = cx_w;
				mul_req.b     = cx_w;
				if (mul_rsp.done) begin
					state_d = S_CYY;
				end
			end
			S_CYY: begin
				mul_req.start = !pend_q;
				mul_req.a     = cy_w;
				mul_req.b     = cy_w;
				if (mul_rsp.done) begin
					state_d = S_C2;
				end
			end
			S_C2: begin
				if (c2_big) begin
					// Far outside both regions: go straight to the orbit, or finish when the limit is zero.
					if (lim_q == '0) begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_STEP1;
					end
				end else begin
					mul_req.start = !pend_q;
					mul_req.a     = c2_q;
					mul_req.b     = c2_q;
					if (mul_rsp.done) begin
						state_d = S_DD;
					end
				end
			end
			S_DD: begin
				mul_req.start = !pend_q;
				mul_req.a     = d_w;
				mul_req.b     = d_w;
				if (mul_rsp.done) begin
					state_d = S_E1;
				end
			end
			S_E1: state_d = S_E2;
			S_E2: state_d = S_E3;
			S_E3: state_d = S_E4;
			S_E4: begin
				if (rej) begin
					fin                    = 1'b1;
					fin_res.rejected_early = 1'b1;
					state_d                = S_IDLE;
				end else if (lim_q == '0) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_STEP1;
				end
			end
			S_STEP1: state_d = S_STEP2;
			S_STEP2: state_d = S_SX;
			S_SX: begin
				mul_req.start = !pend_q;
				mul_req.a     = zx_q;
				mul_req.b     = zx_q;
				if (mul_rsp.done) begin
					state_d = S_SY;
				end
			end
			S_SY: begin
				mul_req.start = !pend_q;
				mul_req.a     = zy_q;
				mul_req.b     = zy_q;
				if (mul_rsp.done) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (esc) begin
					fin                  = 1'b1;
					fin_res.escaped      = 1'b1;
					fin_res.escape_count = ESC_W'(n_q);
					state_d              = S_IDLE;
				end else if (n_q == lim_q) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_XY;
				end
			end
			S_XY: begin
				mul_req.start = !pend_q;
				mul_req.a     = zx_q;
				mul_req.b     = zy_q;
				if (mul_rsp.done) begin
					state_d = S_STEP1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outstanding multiply and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
			if (mul_req.start) begin
				pend_q <= 1'b1;
			end else if (mul_rsp.done) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Working registers, loaded as the sequencer walks the formulas.
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= fin_res;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cx_q  <= point.c_real;
					cy_q  <= point.c_imag;
					lim_q <= lim_eff;
				end
			end
			S_CXX: begin
				if (mul_rsp.done) begin
					sqx_q <= mul_rsp.p;
				end
			end
			S_CYY: begin
				if (mul_rsp.done) begin
					sqy_q <= mul_rsp.p;
					c2_q  <= sat_add(sqx_q, mul_rsp.p);
				end
			end
			S_C2: begin
				if (mul_rsp.done) begin
					m_q <= mul_rsp.p;
				end
			end
			S_DD: begin
				if (mul_rsp.done) begin
					dd_q <= mul_rsp.p;
				end
			end
			S_E1: begin
				t_q <= sat_mulk(c2_q, K_CARD_C2);
				g_q <= sat_add(dd_q, sqy_q);
			end
			S_E2: h_q <= sat_sub(sat_mulk(m_q, K_CARD_SQ), t_q);
			S_E3: h_q <= sat_add(h_q, sat_mulk(cx_w, K_CARD_CX));
			S_STEP1: t_q <= sat_sub(sqx_q, sqy_q);
			S_STEP2: begin
				zx_q <= sat_add(t_q, cx_w);
				zy_q <= sat_add(sat_mulk(m_q, K_DOUBLE), cy_w);
			end
			S_SX: begin
				if (mul_rsp.done) begin
					sqx_q <= mul_rsp.p;
				end
			end
			S_SY: begin
				if (mul_rsp.done) begin
					sqy_q <= mul_rsp.p;
				end
			end
			S_CHK: n_q <= n_q + CNT_W'(1);
			S_XY: begin
				if (mul_rsp.done) begin
					m_q <= mul_rsp.p;
				end
			end
			default: begin
			end
		endcase
		// The orbit starts at zero, so all three products start at zero.
		if (begin_iter) begin
			sqx_q <= '0;
			sqy_q <= '0;
			m_q   <= '0;
			n_q   <= CNT_W'(1);
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== sv/mandelbrot_escape_time_iterator.sv =====
// Each 64-bit fixed-point product runs on the one 32x32 multiplier; an orbit step uses
// three products. A new point is taken in the cycle the strobe shows.
// Reset clears the sequencer and sets the iteration limit to 800; results cannot be stalled.
`include "assert_macros.svh"

module mandelbrot_escape_time_iterator #(
	parameter int FRAC_BITS  = 28,
	parameter int COUNT_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  mbi_pkg::item_t              point,
	input  logic                        cfg_we,
	input  logic [mbi_pkg::LIMIT_W-1:0] cfg_wdata,
	output logic                        done,
	output mbi_pkg::result_t            result
);
	import mbi_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	mul_req_t           mul_req;
	mul_rsp_t           mul_rsp;

	// Iteration limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Sequencer and working registers.
	mbi_core #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.point   (point),
		.limit   (limit_q),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.mul_req (mul_req),
		.mul_rsp (mul_rsp)
	);

	// Shared fixed-point multiplier.
	mbi_mulq #(
		.FRAC_BITS (FRAC_BITS)
	) u_mulq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// A rejected point never carries an escape count.
	`ASSERT_IMPLIES(a_rej_clean, clk, arst_n, done && result.rejected_early, !result.escaped && result.escape_count == '0)
	// An escape is always reported at a step of one or more.
	`ASSERT_IMPLIES(a_esc_count, clk, arst_n, done && result.escaped, result.escape_count != '0 && !result.rejected_early)
	// An accepted beat makes the block busy in the next cycle.
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// The result strobe only shows once the sequencer is back in idle.
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy)

endmodule
